// File: hw/rtl/soft_timer_bank_top_macros.svh
// ----------------------------------------------------------------------------
// soft timer bank assertion macros
// shared concurrent assertion forms for the timer bank checker
// ----------------------------------------------------------------------------
`ifndef SOFT_TIMER_BANK_TOP_MACROS_SVH
`define SOFT_TIMER_BANK_TOP_MACROS_SVH

// same-cycle implication
`define STB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("soft timer bank assertion failed");

// next-cycle implication
`define STB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("soft timer bank assertion failed");

`endif

// File: hw/rtl/stb_pkg.sv
// ----------------------------------------------------------------------------
// stb_pkg
// shared types and constants of the soft timer bank
// ----------------------------------------------------------------------------
`default_nettype none

package stb_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int HANDLE_SLOTS   = 16;
  localparam int HANDLE_W       = 4;
  localparam int TICK_W         = 16;
  localparam logic [TICK_W-1:0] MAX_TICKS_RST = 16'd30000;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_RESTART = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_ALLOC,
    S_REB_RD,
    S_REB_WR,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/stb_store.sv
// ----------------------------------------------------------------------------
// stb_store
// start value memory, one write and one registered read port, per-entry
// valid bits so that unwritten entries read as zero after reset
// ----------------------------------------------------------------------------
`default_nettype none

module stb_store #(
  parameter int DEPTH = stb_pkg::NUM_TIMERS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      wr_en,
  input  wire logic [AW-1:0]             wr_addr,
  input  wire logic [stb_pkg::TICK_W-1:0] wr_data,
  input  wire logic                      rd_en,
  input  wire logic [AW-1:0]             rd_addr,
  output logic      [stb_pkg::TICK_W-1:0] rd_data
);
  import stb_pkg::*;

  logic [TICK_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid_r;
  logic [TICK_W-1:0] rd_data_r;
  logic              rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else if (rd_en) begin
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

`default_nettype wire

// File: hw/rtl/stb_ctrl.sv
// ----------------------------------------------------------------------------
// stb_ctrl
// sequencer of the soft timer bank: tick counter, busy flags, serial
// allocate scan, serial rebase sweep and result register
// ----------------------------------------------------------------------------
`default_nettype none

module stb_ctrl #(
  parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF,
  parameter int AW         = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [stb_pkg::TICK_W-1:0]   cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  in_opcode,
  input  wire logic [stb_pkg::HANDLE_W-1:0] in_handle,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_ok,
  output logic      [stb_pkg::HANDLE_W-1:0] out_handle_out,
  output logic      [stb_pkg::TICK_W-1:0]   out_elapsed,
  output logic                             mem_wr_en,
  output logic      [AW-1:0]               mem_wr_addr,
  output logic      [stb_pkg::TICK_W-1:0]   mem_wr_data,
  output logic                             mem_rd_en,
  output logic      [AW-1:0]               mem_rd_addr,
  input  wire logic [stb_pkg::TICK_W-1:0]   mem_rd_data
);
  import stb_pkg::*;

  localparam int LIM = (NUM_TIMERS < HANDLE_SLOTS) ? NUM_TIMERS : HANDLE_SLOTS;
  localparam logic [AW-1:0] IDX_LAST   = AW'(NUM_TIMERS - 1);
  localparam logic [AW-1:0] ALLOC_LAST = AW'(LIM - 1);

  state_t                state_r, state_nxt;
  logic [TICK_W-1:0]     max_r;
  logic [TICK_W-1:0]     count_r, count_nxt;
  logic [TICK_W-1:0]     reb_amt_r, reb_amt_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic [NUM_TIMERS-1:0] busy_r, busy_nxt;
  logic                  res_ok_r, res_ok_nxt;
  logic [HANDLE_W-1:0]   res_h_r, res_h_nxt;
  logic [TICK_W-1:0]     res_el_r, res_el_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_ok_r;
  logic [HANDLE_W-1:0]   out_h_r;
  logic [TICK_W-1:0]     out_el_r;

  logic              in_acc;
  logic              h_ok;
  logic [TICK_W-1:0] cnt_inc;
  logic              out_free;
  op_t               op;

  assign op       = op_t'(in_opcode);
  assign in_acc   = in_valid && (state_r == S_IDLE);
  assign h_ok     = 32'(in_handle) < NUM_TIMERS;
  assign cnt_inc  = count_r + 1'b1;
  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (op)
            OP_TICK:    state_nxt = (cnt_inc >= max_r) ? S_REB_RD : S_IDLE;
            OP_ALLOC:   state_nxt = S_ALLOC;
            OP_RESTART: state_nxt = S_EMIT;
            OP_READ:    state_nxt = h_ok ? S_RD : S_EMIT;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD: state_nxt = S_EMIT;
      S_ALLOC: begin
        if (!busy_r[idx_r] || idx_r == ALLOC_LAST) begin
          state_nxt = S_EMIT;
        end
      end
      S_REB_RD: begin
        if (busy_r[idx_r]) begin
          state_nxt = S_REB_WR;
        end else if (idx_r == IDX_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_REB_WR: state_nxt = (idx_r == IDX_LAST) ? S_IDLE : S_REB_RD;
      S_EMIT:   state_nxt = out_free ? S_IDLE : S_EMIT;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready      = (state_r == S_IDLE);
    count_nxt     = count_r;
    reb_amt_nxt   = reb_amt_r;
    idx_nxt       = idx_r;
    busy_nxt      = busy_r;
    res_ok_nxt    = res_ok_r;
    res_h_nxt     = res_h_r;
    res_el_nxt    = res_el_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = AW'(in_handle);
    mem_wr_data   = count_r;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = AW'(in_handle);
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_ok_nxt = h_ok;
          res_h_nxt  = '0;
          res_el_nxt = '0;
          idx_nxt    = '0;
          unique case (op)
            OP_TICK: begin
              if (cnt_inc >= max_r) begin
                reb_amt_nxt = cnt_inc;
                count_nxt   = '0;
              end else begin
                count_nxt = cnt_inc;
              end
            end
            OP_ALLOC: ;
            OP_RESTART: mem_wr_en = h_ok;
            OP_READ:    mem_rd_en = h_ok;
            default: ;
          endcase
        end
      end
      S_RD: res_el_nxt = count_r - mem_rd_data;
      S_ALLOC: begin
        if (!busy_r[idx_r]) begin
          busy_nxt[idx_r] = 1'b1;
          res_ok_nxt      = 1'b1;
          res_h_nxt       = HANDLE_W'(idx_r);
        end else if (idx_r == ALLOC_LAST) begin
          res_ok_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_REB_RD: begin
        mem_rd_addr = idx_r;
        if (busy_r[idx_r]) begin
          mem_rd_en = 1'b1;
        end else if (idx_r != IDX_LAST) begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_REB_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = idx_r;
        mem_wr_data = mem_rd_data - reb_amt_r;
        if (idx_r != IDX_LAST) begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_r       <= MAX_TICKS_RST;
      count_r     <= '0;
      busy_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    reb_amt_r <= reb_amt_nxt;
    idx_r     <= idx_nxt;
    res_ok_r  <= res_ok_nxt;
    res_h_r   <= res_h_nxt;
    res_el_r  <= res_el_nxt;
    if (state_r == S_EMIT && out_free) begin
      out_ok_r <= res_ok_r;
      out_h_r  <= res_h_r;
      out_el_r <= res_el_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_handle_out = out_h_r;
  assign out_elapsed    = out_el_r;

endmodule

`default_nettype wire

// File: hw/rtl/soft_timer_bank_top.sv
// ----------------------------------------------------------------------------
// soft_timer_bank_top
// pool of software timers sharing one tick counter, start values in memory
// ----------------------------------------------------------------------------
// tick without wrap: counter update only; tick with wrap: rebase sweep over all timers
// allocate: serial scan of busy flags into the result register
// restart: write of the start value; read: registered memory read, then subtract
// one transaction in flight; the output register frees the next accept
// synchronous active-low reset clears counter, busy flags and store valid bits
// ----------------------------------------------------------------------------
`default_nettype none

module soft_timer_bank_top #(
  parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [stb_pkg::TICK_W-1:0]   cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  in_opcode,
  input  wire logic [stb_pkg::HANDLE_W-1:0] in_handle,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_ok,
  output logic      [stb_pkg::HANDLE_W-1:0] out_handle_out,
  output logic      [stb_pkg::TICK_W-1:0]   out_elapsed
);
  import stb_pkg::*;

  localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  logic              mem_wr_en;
  logic [AW-1:0]     mem_wr_addr;
  logic [TICK_W-1:0] mem_wr_data;
  logic              mem_rd_en;
  logic [AW-1:0]     mem_rd_addr;
  logic [TICK_W-1:0] mem_rd_data;

  stb_ctrl #(
    .NUM_TIMERS (NUM_TIMERS),
    .AW         (AW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_handle      (in_handle),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_ok         (out_ok),
    .out_handle_out (out_handle_out),
    .out_elapsed    (out_elapsed),
    .mem_wr_en      (mem_wr_en),
    .mem_wr_addr    (mem_wr_addr),
    .mem_wr_data    (mem_wr_data),
    .mem_rd_en      (mem_rd_en),
    .mem_rd_addr    (mem_rd_addr),
    .mem_rd_data    (mem_rd_data)
  );

  stb_store #(
    .DEPTH (NUM_TIMERS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

`default_nettype wire

// File: hw/rtl/stb_checker.sv
// ----------------------------------------------------------------------------
// stb_checker
// port-level assertions of the soft timer bank, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "soft_timer_bank_top_macros.svh"

module stb_port_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic [1:0]                  in_opcode,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic                        out_ok,
  input wire logic [stb_pkg::HANDLE_W-1:0] out_handle_out,
  input wire logic [stb_pkg::TICK_W-1:0]   out_elapsed
);
  import stb_pkg::*;

  logic op_take;
  logic out_fail;
  logic out_zero;
  logic out_has_el;
  logic out_read_ok;

  assign op_take     = in_valid && in_ready && (in_opcode != OP_TICK);
  assign out_fail    = out_valid && !out_ok;
  assign out_zero    = (out_handle_out == '0) && (out_elapsed == '0);
  assign out_has_el  = out_valid && (out_elapsed != '0);
  assign out_read_ok = out_ok && (out_handle_out == '0);

  `STB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `STB_ASSERT_NEXT(a_busy_after_op, clk, rst_n, op_take, !in_ready)
  `STB_ASSERT_NOW(a_fail_zero, clk, rst_n, out_fail, out_zero)
  `STB_ASSERT_NOW(a_elapsed_read, clk, rst_n, out_has_el, out_read_ok)

endmodule

bind soft_timer_bank_top stb_port_checker u_stb_checker (.*);

`default_nettype wire

// File: verif/stb_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stb_checker
// watches the request and reply channels of the soft timer bank, keeps its
// own copy of the tick counter, start values and busy flags, predicts each
// reply and compares it field by field with what the block returns
// ----------------------------------------------------------------------------

module stb_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [stb_pkg::TICK_W-1:0]   cfg_wdata,
  input  wire logic                        in_valid,
  input  wire logic                        in_ready,
  input  wire logic [1:0]                  in_opcode,
  input  wire logic [stb_pkg::HANDLE_W-1:0] in_handle,
  input  wire logic                        out_valid,
  input  wire logic                        out_ready,
  input  wire logic                        out_ok,
  input  wire logic [stb_pkg::HANDLE_W-1:0] out_handle_out,
  input  wire logic [stb_pkg::TICK_W-1:0]   out_elapsed,
  output int                               fail_count,
  output int                               pending_count
);

  import stb_pkg::*;

  localparam int NUM_SLOTS = NUM_TIMERS_DEF;

  typedef struct packed {
    logic                ok;
    logic [HANDLE_W-1:0] slot;
    logic [TICK_W-1:0]   elapsed;
  } timer_reply_t;

  logic [TICK_W-1:0] tick_now;
  logic [TICK_W-1:0] wrap_at;
  logic [TICK_W-1:0] start_val [NUM_SLOTS];
  logic              claimed   [NUM_SLOTS];
  timer_reply_t      reply_q   [$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  // advance the shared counter, rebasing busy timers when it hits the limit
  task automatic advance_tick();
    tick_now = tick_now + 1'b1;
    if (tick_now >= wrap_at) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (claimed[i]) begin
          start_val[i] = start_val[i] - tick_now;
        end
      end
      tick_now = '0;
    end
  endtask

  // update the timer state for one request and queue the reply it causes
  task automatic predict_reply(input op_t op, input logic [HANDLE_W-1:0] h);
    timer_reply_t r;
    bit           granted;
    r       = '0;
    granted = 1'b0;
    case (op)
      OP_TICK: begin
        advance_tick();
      end
      OP_ALLOC: begin
        for (int i = 0; i < NUM_SLOTS && i < HANDLE_SLOTS; i++) begin
          if (!granted && !claimed[i]) begin
            claimed[i] = 1'b1;
            r.ok       = 1'b1;
            r.slot     = HANDLE_W'(i);
            granted    = 1'b1;
          end
        end
        reply_q.push_back(r);
      end
      OP_RESTART: begin
        if (int'(h) < NUM_SLOTS) begin
          start_val[h] = tick_now;
          r.ok         = 1'b1;
        end
        reply_q.push_back(r);
      end
      default: begin
        if (int'(h) < NUM_SLOTS) begin
          r.ok      = 1'b1;
          r.elapsed = tick_now - start_val[h];
        end
        reply_q.push_back(r);
      end
    endcase
  endtask

  always @(posedge clk) begin
    timer_reply_t want;
    if (!rst_n) begin
      tick_now = '0;
      wrap_at  = MAX_TICKS_RST;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        start_val[i] = '0;
        claimed[i]   = 1'b0;
      end
      reply_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          $error("reply transaction with nothing outstanding");
          fail_count++;
        end else begin
          want = reply_q.pop_front();
          if (out_ok !== want.ok) begin
            $error("ok: expected %0d, actual %0d", want.ok, out_ok);
            fail_count++;
          end
          if (out_handle_out !== want.slot) begin
            $error("handle_out: expected %0d, actual %0d", want.slot, out_handle_out);
            fail_count++;
          end
          if (out_elapsed !== want.elapsed) begin
            $error("elapsed: expected %0d, actual %0d", want.elapsed, out_elapsed);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        wrap_at = cfg_wdata;
      end
      if (in_valid && in_ready) begin
        predict_reply(op_t'(in_opcode), in_handle);
      end
    end
    pending_count = reply_q.size();
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus for the soft timer bank: a directed opening, then random phases
// under several tick limits with random gaps and reply stalls; the checker
// beside the block does the comparing and this module gives the verdict
// ----------------------------------------------------------------------------

module tb_top;

  import stb_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int SETTLE_CYC  = 40;
  localparam int PHASE_ITEMS = 85;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [TICK_W-1:0]   cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          in_opcode;
  logic [HANDLE_W-1:0] in_handle;
  logic                out_valid;
  logic                out_ready;
  logic                out_ok;
  logic [HANDLE_W-1:0] out_handle_out;
  logic [TICK_W-1:0]   out_elapsed;
  int                  fail_count;
  int                  pending_count;
  bit                  no_idle;
  int                  idle_cycles;
  int                  stall_left;

  soft_timer_bank_top #(
    .NUM_TIMERS(NUM_TIMERS_DEF)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_handle     (in_handle),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_ok        (out_ok),
    .out_handle_out(out_handle_out),
    .out_elapsed   (out_elapsed)
  );

  stb_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_handle     (in_handle),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_ok        (out_ok),
    .out_handle_out(out_handle_out),
    .out_elapsed   (out_elapsed),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(5, 40);
  endfunction

  // reply side stalls, mostly short and now and then long
  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 5) == 0) begin
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                   : $urandom_range(1, 3);
        end
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_request(input op_t op, input logic [HANDLE_W-1:0] h);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_handle <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // only while nothing is outstanding; the extra cycles cover a rebase sweep
  task automatic write_tick_limit(input logic [TICK_W-1:0] limit);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= limit;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_random(input int count, input int alloc_pct);
    int   r;
    op_t  op;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < alloc_pct) begin
        op = OP_ALLOC;
      end else if (r < alloc_pct + 40) begin
        op = OP_TICK;
      end else if (r < alloc_pct + 65) begin
        op = OP_RESTART;
      end else begin
        op = OP_READ;
      end
      send_request(op, HANDLE_W'($urandom_range(0, 15)));
    end
  endtask

  // watchdog on cycles without any transaction
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int wrap_plan [8] = '{0, 1, 65535, 7, 40, 3, 200, 2};
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_opcode = OP_TICK;
    in_handle = '0;
    no_idle   = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_tick_limit(MAX_TICKS_RST);
    send_request(OP_READ, 4'd0);
    send_request(OP_RESTART, 4'd15);
    send_request(OP_TICK, 4'd9);
    send_request(OP_TICK, 4'd0);
    send_request(OP_TICK, 4'd15);
    send_request(OP_READ, 4'd15);
    send_request(OP_READ, 4'd0);
    send_request(OP_ALLOC, 4'd7);
    send_request(OP_ALLOC, 4'd15);
    send_request(OP_RESTART, 4'd0);
    send_request(OP_TICK, 4'd0);
    send_request(OP_READ, 4'd0);
    send_request(OP_READ, 4'd1);
    send_request(OP_RESTART, 4'd1);
    send_request(OP_TICK, 4'd0);
    send_request(OP_TICK, 4'd0);
    send_request(OP_READ, 4'd1);
    send_request(OP_READ, 4'd15);
    send_request(OP_ALLOC, 4'd0);
    send_request(OP_RESTART, 4'd2);
    send_request(OP_READ, 4'd2);
    send_request(OP_TICK, 4'd0);
    send_request(OP_READ, 4'd15);

    for (int p = 0; p < 8; p++) begin
      write_tick_limit(TICK_W'(wrap_plan[p]));
      no_idle = (p % 2 == 1) && ($urandom_range(0, 1) == 0);
      run_random(PHASE_ITEMS, (p == 7) ? 25 : 3);
    end
    no_idle = 1'b0;

    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
